### src/sit_pkg.sv
// Shared types and constants for the sorted interval table unit.
// No dependencies.
`timescale 1ns / 1ps
package sit_pkg;
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_SCAN,
      S_INS_SHIFT,
      S_INS_PUT,
      S_REM_SHIFT,
      S_REM_SCAN,
      S_FWD,
      S_BWD,
      S_HIT,
      S_MAX,
      S_DONE
   } state_type;
endpackage

### src/sit_if.sv
// Valid/ready channel carrying one beat of request or response payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface sit_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [1:0]  track;
   logic [31:0] clip_start;
   logic [31:0] clip_length;
   logic [15:0] media_tag;
   logic [5:0]  slot;
   logic [31:0] query_time;
   modport source (output valid, op, track, clip_start, clip_length, media_tag, slot,
                   query_time, input ready);
   modport sink (input valid, op, track, clip_start, clip_length, media_tag, slot,
                 query_time, output ready);
endinterface

interface sit_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  index;
   logic [31:0] found_start;
   logic [31:0] found_length;
   logic [15:0] found_tag;
   logic [32:0] total_length;
   modport source (output valid, status, index, found_start, found_length, found_tag,
                   total_length, input ready);
   modport sink (input valid, status, index, found_start, found_length, found_tag,
                 total_length, output ready);
endinterface

### src/sorted_interval_table_unit.sv
// Sorted interval table unit: top level with sequencer, per-track registers and entry memory.
// Depends on sit_pkg, sit_if and sit_mem.
//
// Usage: the request channel carries one operation per beat (insert, remove
// or lookup on one track). Each request yields exactly one response beat.
// Insert walks the table to find the position and then shifts the tail up
// one word at a time; remove shifts the tail down and rescans all
// entries for the track end; lookup walks from the track's cursor forward,
// then backward. Each memory step is one read followed by one use of the data.
// Insert, remove and lookup then refresh the overall end over all tracks,
// as does op 3; a full table, a bad track, a bad slot or an empty lookup
// answers without that refresh.
// One item is in work at a time; a new request is taken in idle once the
// previous response has left or leaves in the same cycle, and the response
// register holds while the receiver stalls. Reset clears counts, cursors
// and track ends; the entry memory needs no clearing since only slots below
// the count are read.
`timescale 1ns / 1ps
module sorted_interval_table_unit #(
   parameter int TRACKS    = 4,
   parameter int ENTRIES   = 64,
   parameter int TIME_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   sit_req_if.sink   req,
   sit_rsp_if.source rsp
);
   import sit_pkg::*;

   localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int EW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int AW = TW + EW;
   localparam int DW = 2 * TIME_BITS + 16;
   localparam int XW = TIME_BITS + 1;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff [TRACKS];
   logic [EW-1:0] cursor_ff [TRACKS];
   logic [XW-1:0] tend_ff [TRACKS];
   logic [XW-1:0] oend_ff, oend_in;

   logic [TW-1:0]        trk_ff;
   logic [TIME_BITS-1:0] st_ff, len_ff, q_ff;
   logic [15:0]          tag_ff;
   logic [5:0]           slot_ff;
   logic [CW-1:0]        i_ff, i_in, n_ff;
   logic                 ph_ff, ph_in;
   logic [XW-1:0]        m_ff, m_in;
   logic [TW:0]          t_ff, t_in;

   logic       rv_ff;
   status_type rst_ff, rst_in;
   logic [5:0] ridx_ff, ridx_in;
   logic [TIME_BITS-1:0] rfs_ff, rfl_ff, rfs_in, rfl_in;
   logic [15:0] rft_ff, rft_in;

   logic          wr_en;
   logic [EW-1:0] wr_slot, rd_slot;
   logic [DW-1:0] wr_data, rd_data;
   logic [TIME_BITS-1:0] e_st, e_len;
   logic [XW-1:0] e_end;
   logic          e_hold;
   logic          trk_ok;
   logic          track_wr, cur_wr;
   logic [CW-1:0] count_new;
   logic [XW-1:0] tend_new;
   logic [EW-1:0] cur_new;

   sit_mem #(.DEPTH(TRACKS * ENTRIES), .WIDTH(DW)) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(AW'(trk_ff) * AW'(ENTRIES) + AW'(wr_slot)),
      .wr_data(wr_data),
      .rd_addr(AW'(trk_ff) * AW'(ENTRIES) + AW'(rd_slot)),
      .rd_data(rd_data)
   );

   assign e_st   = rd_data[DW-1 -: TIME_BITS];
   assign e_len  = rd_data[TIME_BITS+15 -: TIME_BITS];
   assign e_end  = XW'(e_st) + XW'(e_len);
   assign e_hold = (q_ff >= e_st) && (XW'(q_ff) < e_end);
   assign trk_ok = 32'(req.track) < 32'(TRACKS);

   assign req.ready = (state_ff == S_IDLE) && (!rv_ff || rsp.ready);
   assign rsp.valid = rv_ff;
   assign rsp.status = rst_ff;
   assign rsp.index = ridx_ff;
   assign rsp.found_start = 32'(rfs_ff);
   assign rsp.found_length = 32'(rfl_ff);
   assign rsp.found_tag = rft_ff;
   assign rsp.total_length = 33'(oend_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               if (!trk_ok) begin
                  state_in = S_DONE;
               end else begin
                  case (op_type'(req.op))
                     OP_INSERT: state_in = S_INS_SCAN;
                     OP_REMOVE: state_in = S_REM_SHIFT;
                     OP_LOOKUP: state_in = S_FWD;
                     default:   state_in = S_MAX;
                  endcase
               end
            end
         end
         S_INS_SCAN: begin
            if (n_ff == CW'(ENTRIES)) state_in = S_DONE;
            else if (i_ff >= n_ff || (ph_ff && e_st > st_ff)) state_in = S_INS_SHIFT;
         end
         S_INS_SHIFT: begin
            if (i_ff <= m_ff[CW-1:0]) state_in = S_INS_PUT;
         end
         S_INS_PUT: state_in = S_MAX;
         S_REM_SHIFT: begin
            if (CW'(slot_ff) >= n_ff) state_in = S_DONE;
            else if (i_ff + 1'b1 >= n_ff) state_in = S_REM_SCAN;
         end
         S_REM_SCAN: begin
            if (n_ff == CW'(1) || (ph_ff && i_ff + 2'd2 >= n_ff)) state_in = S_MAX;
         end
         S_FWD: begin
            if (n_ff == '0) state_in = S_DONE;
            else if (i_ff >= n_ff) state_in = S_BWD;
            else if (ph_ff && (q_ff < e_st)) state_in = S_BWD;
            else if (ph_ff && e_hold) state_in = S_HIT;
         end
         S_BWD: begin
            if (!ph_ff && i_ff == '0) state_in = S_MAX;
            else if (ph_ff && e_hold) state_in = S_HIT;
         end
         S_HIT: state_in = S_MAX;
         S_MAX: begin
            if (t_ff == (TW+1)'(TRACKS - 1)) state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      i_in = i_ff;
      ph_in = 1'b0;
      m_in = m_ff;
      t_in = '0;
      oend_in = oend_ff;
      rst_in = rst_ff;
      ridx_in = ridx_ff;
      rfs_in = rfs_ff;
      rfl_in = rfl_ff;
      rft_in = rft_ff;
      wr_en = 1'b0;
      wr_slot = i_ff[EW-1:0];
      wr_data = rd_data;
      rd_slot = i_ff[EW-1:0];
      track_wr = 1'b0;
      cur_wr = 1'b0;
      count_new = n_ff;
      tend_new = tend_ff[trk_ff];
      cur_new = cursor_ff[trk_ff];
      case (state_ff)
         S_IDLE: begin
            rst_in = ST_OK;
            ridx_in = '0;
            rfs_in = '0;
            rfl_in = '0;
            rft_in = '0;
            m_in = '0;
            if (!trk_ok) rst_in = ST_RANGE;
            if (req.op == OP_REMOVE) i_in = CW'(req.slot);
            else if (req.op == OP_LOOKUP) i_in = '0;
            else i_in = '0;
         end
         S_INS_SCAN: begin
            if (n_ff == CW'(ENTRIES)) begin
               rst_in = ST_FULL;
            end else if (i_ff >= n_ff || (ph_ff && e_st > st_ff)) begin
               m_in = XW'(i_ff);
               ridx_in = 6'(i_ff);
               i_in = n_ff;
            end else if (ph_ff) begin
               i_in = i_ff + 1'b1;
            end else begin
               ph_in = 1'b1;
            end
         end
         S_INS_SHIFT: begin
            if (i_ff > m_ff[CW-1:0]) begin
               rd_slot = EW'(i_ff - 1'b1);
               if (ph_ff) begin
                  wr_en = 1'b1;
                  i_in = i_ff - 1'b1;
               end else begin
                  ph_in = 1'b1;
               end
            end
         end
         S_INS_PUT: begin
            wr_en = 1'b1;
            wr_slot = m_ff[EW-1:0];
            wr_data = {st_ff, len_ff, tag_ff};
            track_wr = 1'b1;
            count_new = n_ff + 1'b1;
            if (XW'(st_ff) + XW'(len_ff) > tend_ff[trk_ff])
               tend_new = XW'(st_ff) + XW'(len_ff);
         end
         S_REM_SHIFT: begin
            if (CW'(slot_ff) >= n_ff) begin
               rst_in = ST_RANGE;
            end else if (i_ff + 1'b1 >= n_ff) begin
               i_in = '0;
               m_in = '0;
            end else begin
               rd_slot = EW'(i_ff + 1'b1);
               if (ph_ff) begin
                  wr_en = 1'b1;
                  i_in = i_ff + 1'b1;
               end else begin
                  ph_in = 1'b1;
               end
            end
         end
         S_REM_SCAN: begin
            if (n_ff == CW'(1)) begin
               track_wr = 1'b1;
               count_new = '0;
               tend_new = '0;
            end else if (ph_ff) begin
               if (e_end > m_ff) m_in = e_end;
               if (i_ff + 2'd2 >= n_ff) begin
                  track_wr = 1'b1;
                  count_new = n_ff - 1'b1;
                  tend_new = (e_end > m_ff) ? e_end : m_ff;
                  i_in = n_ff;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               ph_in = 1'b1;
            end
         end
         S_FWD: begin
            if (n_ff != '0) begin
               if (i_ff >= n_ff || (ph_ff && (q_ff < e_st))) begin
                  i_in = (CW'(cursor_ff[trk_ff]) > n_ff) ? n_ff : CW'(cursor_ff[trk_ff]);
               end else if (ph_ff && e_hold) begin
                  ridx_in = 6'(i_ff);
               end else if (ph_ff) begin
                  i_in = i_ff + 1'b1;
               end else begin
                  ph_in = 1'b1;
               end
            end else begin
               rst_in = ST_MISS;
            end
         end
         S_BWD: begin
            if (!ph_ff) begin
               if (i_ff == '0) begin
                  rst_in = ST_MISS;
               end else begin
                  i_in = i_ff - 1'b1;
                  rd_slot = EW'(i_ff - 1'b1);
                  ph_in = 1'b1;
               end
            end else if (e_hold) begin
               ridx_in = 6'(i_ff);
            end
         end
         S_HIT: begin
            rfs_in = e_st;
            rfl_in = e_len;
            rft_in = rd_data[15:0];
            cur_wr = 1'b1;
            cur_new = i_ff[EW-1:0];
         end
         S_MAX: begin
            t_in = t_ff + 1'b1;
            if (t_ff == '0) oend_in = tend_ff[0];
            else if (tend_ff[t_ff[TW-1:0]] > oend_ff) oend_in = tend_ff[t_ff[TW-1:0]];
         end
         default: ;
      endcase
      if (state_ff == S_INS_SHIFT) wr_slot = i_ff[EW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         oend_ff <= '0;
         ph_ff <= 1'b0;
         t_ff <= '0;
         for (int k = 0; k < TRACKS; k++) begin
            count_ff[k] <= '0;
            cursor_ff[k] <= '0;
            tend_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ph_ff <= ph_in;
         t_ff <= (state_ff == S_MAX) ? t_in : '0;
         oend_ff <= oend_in;
         if (state_ff == S_DONE) rv_ff <= 1'b1;
         else if (rsp.ready) rv_ff <= 1'b0;
         if (track_wr) begin
            count_ff[trk_ff] <= count_new;
            tend_ff[trk_ff] <= tend_new;
         end
         if (cur_wr) cursor_ff[trk_ff] <= cur_new;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         trk_ff <= TW'(req.track);
         st_ff <= TIME_BITS'(req.clip_start);
         len_ff <= TIME_BITS'(req.clip_length);
         tag_ff <= req.media_tag;
         slot_ff <= req.slot;
         q_ff <= TIME_BITS'(req.query_time);
         n_ff <= trk_ok ? count_ff[TW'(req.track)] : '0;
         i_ff <= (req.op == OP_LOOKUP && trk_ok &&
                  CW'(cursor_ff[TW'(req.track)]) < count_ff[TW'(req.track)]) ?
                 CW'(cursor_ff[TW'(req.track)]) : i_in;
      end else begin
         i_ff <= i_in;
      end
      m_ff <= m_in;
      if (state_ff != S_IDLE || (req.valid && req.ready)) begin
         rst_ff <= rst_in;
         ridx_ff <= ridx_in;
         rfs_ff <= rfs_in;
         rfl_ff <= rfl_in;
         rft_ff <= rft_in;
      end
   end
endmodule

### src/sit_mem.sv
// Entry memory: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module sit_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### verif/sorted_interval_table_unit_test.sv
// Testbench for sorted_interval_table_unit: directed and random table operations,
// each response checked field by field against a behavioral predictor.
// Depends on sit_pkg, sit_if and the unit RTL.
`timescale 1ns / 1ps
module sorted_interval_table_unit_test;
   import sit_pkg::*;

   localparam int NTRK = 4;
   localparam int NENT = 64;

   typedef struct packed {
      status_type  status;
      logic [5:0]  index;
      logic [31:0] found_start;
      logic [31:0] found_length;
      logic [15:0] found_tag;
      logic [32:0] total_length;
   } answer_type;

   logic clock = 0;
   logic reset = 1;

   sit_req_if req ();
   sit_rsp_if rsp ();

   sorted_interval_table_unit dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // predictor state
   logic [31:0] tab_start [NTRK][NENT];
   logic [31:0] tab_len   [NTRK][NENT];
   logic [15:0] tab_tag   [NTRK][NENT];
   int          tab_count [NTRK];
   int          tab_cursor[NTRK];
   logic [32:0] tab_end   [NTRK];

   answer_type answer_q[$];
   int      errors = 0;
   bit      in_quiet = 0;   // long stretch without idling
   bit      hold_rsp = 0;

   function automatic logic [32:0] span_end(int t, int i);
      return {1'b0, tab_start[t][i]} + {1'b0, tab_len[t][i]};
   endfunction

   function automatic bit covers(int t, int i, logic [31:0] q);
      return q >= tab_start[t][i] && {1'b0, q} < span_end(t, i);
   endfunction

   function automatic answer_type table_apply(op_type op, int t, logic [31:0] st,
                                              logic [31:0] ln, logic [15:0] tg,
                                              int s, logic [31:0] q);
      answer_type a;
      int n, pos, b, at;
      bit hit;
      logic [32:0] m;
      a = '0;
      a.status = ST_OK;
      n = tab_count[t];
      case (op)
         OP_INSERT: begin
            if (n >= NENT) begin
               a.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < n && tab_start[t][pos] <= st) pos++;
               for (int i = n; i > pos; i--) begin
                  tab_start[t][i] = tab_start[t][i-1];
                  tab_len[t][i]   = tab_len[t][i-1];
                  tab_tag[t][i]   = tab_tag[t][i-1];
               end
               tab_start[t][pos] = st;
               tab_len[t][pos]   = ln;
               tab_tag[t][pos]   = tg;
               tab_count[t] = n + 1;
               if (span_end(t, pos) > tab_end[t]) tab_end[t] = span_end(t, pos);
               a.index = 6'(pos);
            end
         end
         OP_REMOVE: begin
            if (s >= n) begin
               a.status = ST_RANGE;
            end else begin
               for (int i = s; i + 1 < n; i++) begin
                  tab_start[t][i] = tab_start[t][i+1];
                  tab_len[t][i]   = tab_len[t][i+1];
                  tab_tag[t][i]   = tab_tag[t][i+1];
               end
               n--;
               tab_count[t] = n;
               m = 0;
               for (int i = 0; i < n; i++) if (span_end(t, i) > m) m = span_end(t, i);
               tab_end[t] = m;
            end
         end
         OP_LOOKUP: begin
            a.status = ST_MISS;
            hit = 0;
            at = 0;
            if (n > 0) begin
               for (int i = (tab_cursor[t] >= n) ? 0 : tab_cursor[t]; i < n; i++) begin
                  if (q < tab_start[t][i]) break;
                  if (covers(t, i, q)) begin
                     hit = 1;
                     at = i;
                     break;
                  end
               end
               if (!hit) begin
                  b = (tab_cursor[t] > n) ? n : tab_cursor[t];
                  while (b > 0) begin
                     b--;
                     if (covers(t, b, q)) begin
                        hit = 1;
                        at = b;
                        break;
                     end
                  end
               end
               if (hit) begin
                  tab_cursor[t] = at;
                  a.status = ST_OK;
                  a.index = 6'(at);
                  a.found_start = tab_start[t][at];
                  a.found_length = tab_len[t][at];
                  a.found_tag = tab_tag[t][at];
               end
            end
         end
         default: ;
      endcase
      m = 0;
      for (int i = 0; i < NTRK; i++) if (tab_end[i] > m) m = tab_end[i];
      a.total_length = m;
      return a;
   endfunction

   task automatic send_op(op_type op, int t, logic [31:0] st = 0, logic [31:0] ln = 0,
                          logic [15:0] tg = 0, int s = 0, logic [31:0] q = 0);
      if (!in_quiet && $urandom_range(99) < 22) begin
         req.valid <= 0;
         do @(posedge clock); while (!in_quiet && $urandom_range(99) < 22);
      end
      req.valid <= 1;
      req.op <= op;
      req.track <= 2'(t);
      req.clip_start <= st;
      req.clip_length <= ln;
      req.media_tag <= tg;
      req.slot <= 6'(s);
      req.query_time <= q;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      answer_q.push_back(table_apply(op, t, st, ln, tg, s, q));
   endtask

   task automatic drain_answers();
      req.valid <= 0;
      while (answer_q.size() != 0) @(posedge clock);
   endtask

   // response side: stall at random, or hold off on request
   always @(posedge clock) begin
      if (reset) rsp.ready <= 0;
      else rsp.ready <= !hold_rsp && (in_quiet || $urandom_range(99) >= 22);
   end

   always @(posedge clock) begin
      answer_type exp;
      if (!reset && rsp.valid && rsp.ready) begin
         if (answer_q.size() == 0) begin
            $error("response beat with no expectation");
            errors++;
         end else begin
            exp = answer_q.pop_front();
            if (rsp.status !== exp.status) begin
               $error("status exp %0d got %0d", exp.status, rsp.status); errors++;
            end
            if (rsp.index !== exp.index) begin
               $error("index exp %0d got %0d", exp.index, rsp.index); errors++;
            end
            if (rsp.found_start !== exp.found_start) begin
               $error("found_start exp %h got %h", exp.found_start, rsp.found_start);
               errors++;
            end
            if (rsp.found_length !== exp.found_length) begin
               $error("found_length exp %h got %h", exp.found_length, rsp.found_length);
               errors++;
            end
            if (rsp.found_tag !== exp.found_tag) begin
               $error("found_tag exp %h got %h", exp.found_tag, rsp.found_tag); errors++;
            end
            if (rsp.total_length !== exp.total_length) begin
               $error("total_length exp %h got %h", exp.total_length, rsp.total_length);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] rand_time();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h0000_ffff);
         default: return $urandom_range(32'h0040_0000);
      endcase
   endfunction

   // lookup time aimed near a stored interval when one exists
   function automatic logic [31:0] aim_time(int t);
      int i;
      if (tab_count[t] == 0 || $urandom_range(3) == 0) return rand_time();
      i = $urandom_range(tab_count[t] - 1);
      return tab_start[t][i] + ($urandom_range(3) == 0 ? 0 : $urandom_range(tab_len[t][i]));
   endfunction

   task automatic test_extremes();
      send_op(OP_LOOKUP, 0, .q(0));
      send_op(OP_REMOVE, 0, .s(0));
      send_op(OP_INSERT, 0, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
      send_op(OP_INSERT, 0, 0, 0, 0);
      send_op(OP_INSERT, 0, 32'h10000, 32'h20000, 16'h5a5a);
      send_op(OP_INSERT, 0, 32'h10000, 32'h8000, 16'ha5a5);
      send_op(OP_LOOKUP, 0, .q(32'h10000));
      send_op(OP_LOOKUP, 0, .q(32'h2ffff));
      send_op(OP_LOOKUP, 0, .q(32'hffff_fffe));
      send_op(OP_LOOKUP, 0, .q(32'h0));
      send_op(OP_LOOKUP, 0, .q(32'h10000));
      send_op(OP_REMOVE, 0, .s(63));
      send_op(OP_REMOVE, 0, .s(3));
      send_op(OP_REMOVE, 0, .s(1));
      send_op(OP_LOOKUP, 0, .q(32'h10000));
      send_op(OP_NONE, 3, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 63, 32'hffff_ffff);
      send_op(OP_INSERT, 3, 32'h1234, 32'h10, 16'h1);
      send_op(OP_LOOKUP, 3, .q(32'h1240));
      send_op(OP_REMOVE, 3, .s(0));
      send_op(OP_LOOKUP, 3, .q(32'h1240));
   endtask

   task automatic test_full_table();
      for (int i = 0; i < NENT + 2; i++)
         send_op(OP_INSERT, 1, $urandom_range(200) << 12, $urandom_range(8192),
                 16'($urandom));
      send_op(OP_LOOKUP, 1, .q(32'h50000));
      for (int i = 0; i < 40; i++) send_op(OP_REMOVE, 1, .s($urandom_range(63)));
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 12; i++)
            send_op(OP_INSERT, 2, rand_time(), rand_time(), 16'($urandom));
      join
      drain_answers();
   endtask

   task automatic test_random(int count);
      int t, r;
      for (int k = 0; k < count; k++) begin
         in_quiet = (k >= 200 && k < 300);
         t = $urandom_range(3);
         r = $urandom_range(99);
         if (r < 40 && tab_count[t] < NENT)
            send_op(OP_INSERT, t, rand_time(), rand_time(), 16'($urandom));
         else if (r < 55)
            send_op(OP_REMOVE, t, .s(tab_count[t] > 0 && $urandom_range(4) != 0 ?
                    $urandom_range(tab_count[t] - 1) : $urandom_range(63)));
         else if (r < 97)
            send_op(OP_LOOKUP, t, .q(aim_time(t)));
         else if (r < 98)
            send_op(OP_INSERT, t, rand_time(), rand_time(), 16'($urandom));
         else
            send_op(OP_NONE, t, $urandom, $urandom, 16'($urandom), $urandom_range(63),
                    $urandom);
         if (k == 500) drain_answers();
      end
      in_quiet = 0;
   endtask

   initial begin
      for (int t = 0; t < NTRK; t++) begin
         tab_count[t] = 0;
         tab_cursor[t] = 0;
         tab_end[t] = 0;
      end
      req.valid = 0;
      req.op = OP_INSERT;
      req.track = 0;
      req.clip_start = 0;
      req.clip_length = 0;
      req.media_tag = 0;
      req.slot = 0;
      req.query_time = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_extremes();
      test_full_table();
      test_backpressure();
      test_random(700);
      drain_answers();
      repeat (400) @(posedge clock);
      if (errors == 0) $display("sorted_interval_table_unit_test: PASS");
      else $display("sorted_interval_table_unit_test: FAIL");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("sorted_interval_table_unit_test: FAIL");
      $finish;
   end
endmodule

### sorted_interval_table_unit.f
src/sit_pkg.sv
src/sit_if.sv
src/sit_mem.sv
src/sorted_interval_table_unit.sv
verif/sorted_interval_table_unit_test.sv
